// ----- rtl/spcf_pkg.sv -----
`default_nettype none
package spcf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DW      = 32;               // field width
    localparam int IN_W    = 7 * DW;           // s_tdata width
    localparam int OUT_W   = 136;              // m_tdata width, 130 bits padded to bytes
    localparam int CFG_IDX_W = 3;

    localparam int VW      = DW + 2;           // exact position minus centre
    localparam int AW      = DW + 1;           // magnitude of vector component
    localparam int SQW     = 2 * AW;           // one square
    localparam int SUMW    = SQW + 1;          // sum of three squares
    localparam int ROOTW   = 35;               // floor sqrt of the sum
    localparam int RADW    = 2 * ROOTW;        // radicand padded to whole digit pairs
    localparam int REMW    = ROOTW + 2;        // sqrt partial remainder
    localparam int SQ_STEPS = ROOTW;
    localparam int CW      = DW - 1;           // contact range: 31 bit magnitudes
    localparam int KSW     = CW + DW;          // stiffness times load scale magnitude
    localparam int PAW     = 2 * CW;           // component times penetration
    localparam int PW      = PAW + KSW;        // full product
    localparam int QW      = DW;               // quotient bits
    localparam int GAPW    = ROOTW + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_STIFFNESS = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                 valid;
        logic [2:0][VW-1:0]   v;
        logic [DW-1:0]        ls;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        logic [2:0][AW-1:0]   av;
        logic [2:0][SQW-1:0]  sq;
        logic [2:0]           neg;
        logic                 sneg;
        logic [KSW-1:0]       ks;
    } s2_t;

    typedef struct packed {
        logic [2:0][CW-1:0]   av;
        logic [2:0]           neg;
        logic                 sneg;
        logic [KSW-1:0]       ks;
        logic                 degen;
    } side_t;

    typedef struct packed {
        logic                 valid;
        logic [RADW-1:0]      rad;
        logic [REMW-1:0]      rem;
        logic [ROOTW-1:0]     root;
        side_t                side;
    } sqrt_stage_t;

    typedef struct packed {
        logic [2:0]           negf;
        logic                 contact;
        logic                 degen;
        logic [DW-1:0]        gap;
        logic [CW-1:0]        distance;
    } tail_t;

    typedef struct packed {
        logic                 valid;
        tail_t                tail;
        logic [2:0][CW-1:0]   av;
        logic [CW-1:0]        pen;
        logic [KSW-1:0]       ks;
    } gap_stage_t;

    typedef struct packed {
        logic                 valid;
        tail_t                tail;
        logic [2:0][PAW-1:0]  pa;
        logic [KSW-1:0]       ks;
    } m1_t;

    typedef struct packed {
        logic                 valid;
        tail_t                tail;
        logic [2:0][63:0]     p00;
        logic [2:0][62:0]     p01;
        logic [2:0][61:0]     p10;
        logic [2:0][60:0]     p11;
    } m2_t;

    typedef struct packed {
        logic                 valid;
        tail_t                tail;
        logic [2:0][PW-1:0]   prod;
    } m3_t;

    typedef struct packed {
        logic                 valid;
        tail_t                tail;
        logic [2:0]           sat;
        logic [2:0][CW-1:0]   rem;
        logic [2:0][QW-1:0]   nlo;
        logic [2:0][QW-1:0]   q;
    } div_stage_t;

    typedef struct packed {
        logic                 valid;
        logic [2:0][DW-1:0]   f;
        logic [DW-1:0]        gap;
        logic                 contact;
        logic                 degen;
    } out_t;

endpackage
`default_nettype wire

// ----- rtl/sphere_penalty_contact_force_top.sv -----
`default_nettype none
// Penalty contact force of one node against a rigid sphere, signed fixed point with
// FRAC_BITS fraction bits. Each s_tdata transaction is one node; each m_tdata transaction
// is its force, gap and flags, in the same order. The datapath is a fully pipelined chain
// of 76 register stages (three stages of vector and square forming, a 35 stage digit-pair
// square root, a gap stage, three multiply stages, a scaling stage, a 32 stage restoring
// divider per axis and an output register), so one node is accepted every clock cycle
// while the output is not stalled. A stall on m_tready freezes the whole chain.
// Configuration registers are to be written through cfg_wr_en/cfg_index/cfg_data only
// while no node is in flight; the block itself does not enforce this.
module sphere_penalty_contact_force_top #(
    parameter int FRAC_BITS = spcf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [spcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spcf_pkg::DW-1:0]        cfg_data,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // init_x, init_y, init_z, disp_x, disp_y, disp_z, load_scale
    input  wire logic [spcf_pkg::IN_W-1:0]      s_tdata,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // force_x, force_y, force_z, gap, in_contact, degenerate, zero pad
    output      logic [spcf_pkg::OUT_W-1:0]     m_tdata
);
    import spcf_pkg::*;

    logic signed [DW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [CW-1:0]        radius_reg, stiffness_reg;
    logic                 ce;

    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    sqrt_stage_t sq_reg [0:SQ_STEPS];
    sqrt_stage_t sq_next[0:SQ_STEPS];
    gap_stage_t  g_reg, g_next;
    m1_t         m1_reg, m1_next;
    m2_t         m2_reg, m2_next;
    m3_t         m3_reg, m3_next;
    div_stage_t  dv_reg [0:QW];
    div_stage_t  dv_next[0:QW];
    out_t        o_reg, o_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= CW'(1) << FRAC_BITS;
            stiffness_reg <= CW'(1) << FRAC_BITS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= cfg_data;
                REG_CENTER_Y:  center_y_reg  <= cfg_data;
                REG_CENTER_Z:  center_z_reg  <= cfg_data;
                REG_RADIUS:    radius_reg    <= cfg_data[CW-1:0];
                REG_STIFFNESS: stiffness_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = o_reg.valid;
    assign ce       = !o_reg.valid || m_tready;
    assign s_tready = ce;

    // stage 1: current position minus centre
    always_comb
    begin
        s1_next.valid = s_tvalid;
        s1_next.v[0] = VW'($signed(s_tdata[31:0])) + VW'($signed(s_tdata[127:96]))
                     - VW'(center_x_reg);
        s1_next.v[1] = VW'($signed(s_tdata[63:32])) + VW'($signed(s_tdata[159:128]))
                     - VW'(center_y_reg);
        s1_next.v[2] = VW'($signed(s_tdata[95:64])) + VW'($signed(s_tdata[191:160]))
                     - VW'(center_z_reg);
        s1_next.ls = s_tdata[223:192];
    end

    // stage 2: magnitudes, squares, stiffness times scale
    always_comb
    begin
        logic [VW-1:0] nv;
        logic [DW-1:0] sabs;
        s2_next.valid = s1_reg.valid;
        for (int i = 0; i < 3; i++)
        begin
            nv = VW'(0) - s1_reg.v[i];
            s2_next.neg[i] = s1_reg.v[i][VW-1];
            s2_next.av[i]  = s1_reg.v[i][VW-1] ? nv[AW-1:0] : s1_reg.v[i][AW-1:0];
            s2_next.sq[i]  = SQW'(s2_next.av[i]) * SQW'(s2_next.av[i]);
        end
        s2_next.sneg = s1_reg.ls[DW-1];
        sabs = s1_reg.ls[DW-1] ? (DW'(0) - s1_reg.ls) : s1_reg.ls;
        s2_next.ks = KSW'(stiffness_reg) * KSW'(sabs);
    end

    // stage 3: sum of squares, enters the square root
    always_comb
    begin
        sq_next[0].valid = s2_reg.valid;
        sq_next[0].rad   = RADW'(SUMW'(s2_reg.sq[0]) + SUMW'(s2_reg.sq[1])
                               + SUMW'(s2_reg.sq[2]));
        sq_next[0].rem   = '0;
        sq_next[0].root  = '0;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[0].side.av[i] = s2_reg.av[i][CW-1:0];
        end
        sq_next[0].side.neg   = s2_reg.neg;
        sq_next[0].side.sneg  = s2_reg.sneg;
        sq_next[0].side.ks    = s2_reg.ks;
        sq_next[0].side.degen = (s2_reg.av[0] == '0) && (s2_reg.av[1] == '0)
                              && (s2_reg.av[2] == '0);
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        always_comb
        begin
            rem_sh = {sq_reg[k].rem[REMW-3:0], sq_reg[k].rad[RADW-1:RADW-2]};
            trial  = {sq_reg[k].root, 2'b01};
            sq_next[k+1]      = sq_reg[k];
            sq_next[k+1].rad  = {sq_reg[k].rad[RADW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_next[k+1].rem  = rem_sh - trial;
                sq_next[k+1].root = {sq_reg[k].root[ROOTW-2:0], 1'b1};
            end
            else
            begin
                sq_next[k+1].rem  = rem_sh;
                sq_next[k+1].root = {sq_reg[k].root[ROOTW-2:0], 1'b0};
            end
        end
    end

    // gap and penetration
    always_comb
    begin
        logic [GAPW-1:0] gw;
        logic [ROOTW-1:0] distance;
        distance = sq_reg[SQ_STEPS].root;
        gw   = {1'b0, distance} - GAPW'(radius_reg);
        g_next.valid        = sq_reg[SQ_STEPS].valid;
        g_next.tail.contact = gw[GAPW-1];
        g_next.tail.degen   = sq_reg[SQ_STEPS].side.degen;
        g_next.tail.gap     = (!gw[GAPW-1] && (gw[GAPW-2:DW-1] != '0))
                            ? {1'b0, {(DW-1){1'b1}}} : gw[DW-1:0];
        g_next.tail.distance = distance[CW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            g_next.tail.negf[i] = sq_reg[SQ_STEPS].side.neg[i] ^ sq_reg[SQ_STEPS].side.sneg;
        end
        g_next.av  = sq_reg[SQ_STEPS].side.av;
        g_next.pen = radius_reg - distance[CW-1:0];
        g_next.ks  = sq_reg[SQ_STEPS].side.ks;
    end

    // component times penetration
    always_comb
    begin
        m1_next.valid = g_reg.valid;
        m1_next.tail  = g_reg.tail;
        m1_next.ks    = g_reg.ks;
        for (int i = 0; i < 3; i++)
        begin
            m1_next.pa[i] = PAW'(g_reg.av[i]) * PAW'(g_reg.pen);
        end
    end

    // partial products of the wide multiply
    always_comb
    begin
        m2_next.valid = m1_reg.valid;
        m2_next.tail  = m1_reg.tail;
        for (int i = 0; i < 3; i++)
        begin
            m2_next.p00[i] = 64'(m1_reg.pa[i][31:0]) * 64'(m1_reg.ks[31:0]);
            m2_next.p01[i] = 63'(m1_reg.pa[i][31:0]) * 63'(m1_reg.ks[KSW-1:32]);
            m2_next.p10[i] = 62'(m1_reg.pa[i][PAW-1:32]) * 62'(m1_reg.ks[31:0]);
            m2_next.p11[i] = 61'(m1_reg.pa[i][PAW-1:32]) * 61'(m1_reg.ks[KSW-1:32]);
        end
    end

    // sum of partial products
    always_comb
    begin
        m3_next.valid = m2_reg.valid;
        m3_next.tail  = m2_reg.tail;
        for (int i = 0; i < 3; i++)
        begin
            m3_next.prod[i] = PW'(m2_reg.p00[i]) + (PW'(m2_reg.p01[i]) << 32)
                            + (PW'(m2_reg.p10[i]) << 32) + (PW'(m2_reg.p11[i]) << 64);
        end
    end

    // scale down, overflow check, divider entry
    always_comb
    begin
        logic [PW-1:0] n;
        logic [PW-1:0] nhi;
        dv_next[0].valid = m3_reg.valid;
        dv_next[0].tail  = m3_reg.tail;
        dv_next[0].q     = '0;
        for (int i = 0; i < 3; i++)
        begin
            n   = m3_reg.prod[i] >> (2 * FRAC_BITS);
            nhi = n >> QW;
            dv_next[0].sat[i] = nhi >= PW'(m3_reg.tail.distance);
            dv_next[0].rem[i] = nhi[CW-1:0];
            dv_next[0].nlo[i] = n[QW-1:0];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        always_comb
        begin
            logic [QW-1:0] r2;
            logic [QW-1:0] d;
            dv_next[k+1] = dv_reg[k];
            d = QW'(dv_reg[k].tail.distance);
            for (int i = 0; i < 3; i++)
            begin
                r2 = {dv_reg[k].rem[i], dv_reg[k].nlo[i][QW-1]};
                dv_next[k+1].nlo[i] = {dv_reg[k].nlo[i][QW-2:0], 1'b0};
                if (r2 >= d)
                begin
                    r2 = r2 - d;
                    dv_next[k+1].q[i] = {dv_reg[k].q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_next[k+1].q[i] = {dv_reg[k].q[i][QW-2:0], 1'b0};
                end
                dv_next[k+1].rem[i] = r2[CW-1:0];
            end
        end
    end

    // saturation and sign
    always_comb
    begin
        logic [DW-1:0] lim;
        logic [DW-1:0] mag;
        o_next.valid   = dv_reg[QW].valid;
        o_next.gap     = dv_reg[QW].tail.gap;
        o_next.contact = dv_reg[QW].tail.contact;
        o_next.degen   = dv_reg[QW].tail.degen;
        for (int i = 0; i < 3; i++)
        begin
            lim = dv_reg[QW].tail.negf[i] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            mag = (dv_reg[QW].sat[i] || (dv_reg[QW].q[i] > lim)) ? lim : dv_reg[QW].q[i];
            if (!dv_reg[QW].tail.contact || dv_reg[QW].tail.degen)
            begin
                o_next.f[i] = '0;
            end
            else
            begin
                o_next.f[i] = dv_reg[QW].tail.negf[i] ? (DW'(0) - mag) : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            g_reg  <= '0;
            m1_reg <= '0;
            m2_reg <= '0;
            m3_reg <= '0;
            o_reg  <= '0;
        end
        else if (ce)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            g_reg  <= g_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            o_reg  <= o_next;
        end
    end

    for (genvar k = 0; k <= SQ_STEPS; k++)
    begin : g_sq_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_reg[k] <= '0;
            end
            else if (ce)
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    for (genvar k = 0; k <= QW; k++)
    begin : g_dv_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= '0;
            end
            else if (ce)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    assign m_tdata = {6'b0, o_reg.degen, o_reg.contact, o_reg.gap,
                      o_reg.f[2], o_reg.f[1], o_reg.f[0]};

endmodule
`default_nettype wire
